>>> hw/rtl/connection_blocklist_filter_unit_defines.svh
// assertion macros for the connection blocklist filter
`ifndef CONNECTION_BLOCKLIST_FILTER_UNIT_DEFINES_SVH
`define CONNECTION_BLOCKLIST_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CBF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbf assertion failed");
// next-cycle implication
`define CBF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbf assertion failed");
`else
`define CBF_ASSERT_IMP(lbl, ante, cons)
`define CBF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/cbf_pkg.sv
// types, constants and codes of the connection blocklist filter
package cbf_pkg;

    localparam int CGROUP_ENTRIES = 256;
    localparam int IPV4_ENTRIES   = 1024;
    localparam int IPV6_ENTRIES   = 1024;
    localparam int PORT_ENTRIES   = 256;

    localparam int CG_AW = (CGROUP_ENTRIES > 1) ? $clog2(CGROUP_ENTRIES) : 1;
    localparam int V4_AW = (IPV4_ENTRIES > 1) ? $clog2(IPV4_ENTRIES) : 1;
    localparam int V6_AW = (IPV6_ENTRIES > 1) ? $clog2(IPV6_ENTRIES) : 1;
    localparam int PT_AW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

    localparam int MAX_A = (CGROUP_ENTRIES > IPV4_ENTRIES) ? CGROUP_ENTRIES : IPV4_ENTRIES;
    localparam int MAX_B = (IPV6_ENTRIES > PORT_ENTRIES) ? IPV6_ENTRIES : PORT_ENTRIES;
    localparam int CLEAR_LEN = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int CNT_W = $clog2(CLEAR_LEN + 1);

    localparam logic [15:0] FAMILY_V4   = 16'd2;
    localparam logic [15:0] FAMILY_V6   = 16'd10;
    localparam logic [31:0] MAPPED_WORD = 32'h0000ffff;

    localparam logic [2:0] CAUSE_ALLOWED = 3'd0;
    localparam logic [2:0] CAUSE_FAMILY  = 3'd1;
    localparam logic [2:0] CAUSE_CGROUP  = 3'd2;
    localparam logic [2:0] CAUSE_IPV4    = 3'd3;
    localparam logic [2:0] CAUSE_IPV6    = 3'd4;
    localparam logic [2:0] CAUSE_MAPPED  = 3'd5;
    localparam logic [2:0] CAUSE_PORT    = 3'd6;

    typedef enum logic [2:0] {
        MODE_CHECK     = 3'd0,
        MODE_WR_CGROUP = 3'd1,
        MODE_WR_IPV4   = 3'd2,
        MODE_WR_IPV6   = 3'd3,
        MODE_WR_PORT   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SET_CG = 2'd0,
        SET_V4 = 2'd1,
        SET_V6 = 2'd2,
        SET_PT = 2'd3
    } set_t;

    typedef enum logic [3:0] {
        ST_CLEAR    = 4'b0001,
        ST_IDLE     = 4'b0010,
        ST_DISPATCH = 4'b0100,
        ST_SCAN     = 4'b1000
    } state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        hook_is_ipv6;
        logic [15:0] address_family;
        logic [63:0] group_id;
        logic [31:0] dest_ipv4;
        logic [63:0] dest_ipv6_high;
        logic [63:0] dest_ipv6_low;
        logic [15:0] dest_port;
        logic        entry_blocked;
    } in_item_t;

    typedef struct packed {
        logic        allowed;
        logic [2:0]  cause;
        logic        write_done;
        logic [63:0] checked_total;
        logic [63:0] blocked_total;
        logic [63:0] allowed_total;
    } out_item_t;

endpackage

>>> hw/rtl/connection_blocklist_filter_unit.sv
// connection blocklist filter: four exact-match sets scanned in memory
// Each set probe scans its memory at one entry a cycle, ending early on a hit; a
// family mismatch or an unused mode returns its result from dispatch without a scan.
// Throughput: one item at a time, busy until the result strobe; a check visits up
// to four sets, a write one set, applied at the edge that raises the strobe.
// Reset: counters clear; a clearing pass over CLEAR_LEN (1024) entries zeroes all
// valid bits while busy is held high.
`include "connection_blocklist_filter_unit_defines.svh"
module connection_blocklist_filter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cbf_pkg::in_item_t   item,
    output logic                busy,
    output logic                result_valid,
    output cbf_pkg::out_item_t  result
);
    import cbf_pkg::*;

    state_t           state_reg, state_next;
    in_item_t         item_reg, item_next;
    set_t             sel_reg, sel_next;
    logic             mapped_reg, mapped_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pidx_reg, pidx_next;
    logic             free_found_reg, free_found_next;
    logic [CNT_W-1:0] free_idx_reg, free_idx_next;
    logic [63:0]      checked_reg, checked_next;
    logic [63:0]      blocked_reg, blocked_next;
    logic [63:0]      allowed_reg, allowed_next;
    out_item_t        result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    // memories: valid bit on top of each key
    logic [64:0]  cg_mem [CGROUP_ENTRIES];
    logic [32:0]  v4_mem [IPV4_ENTRIES];
    logic [128:0] v6_mem [IPV6_ENTRIES];
    logic [16:0]  pt_mem [PORT_ENTRIES];
    logic [64:0]  cg_rd_reg;
    logic [32:0]  v4_rd_reg;
    logic [128:0] v6_rd_reg;
    logic [16:0]  pt_rd_reg;

    logic             issue;
    logic             w_en;
    logic             w_all;
    logic [CNT_W-1:0] w_idx;
    logic             w_val;
    logic [CNT_W-1:0] sel_depth;
    logic             ent_valid;
    logic             ent_match;
    logic             hit;
    logic             last;
    logic             probe_end;
    logic             free_now_found;
    logic [CNT_W-1:0] free_now_idx;
    logic [31:0]      v4_key;
    logic             is_mapped;
    logic             fam_ok;
    logic [2:0]       hit_cause;

    assign v4_key    = mapped_reg ? item_reg.dest_ipv6_low[31:0] : item_reg.dest_ipv4;
    assign is_mapped = (item_reg.dest_ipv6_high == 64'd0)
                       && (item_reg.dest_ipv6_low[63:32] == MAPPED_WORD);
    assign fam_ok    = item_reg.address_family == (item_reg.hook_is_ipv6 ? FAMILY_V6 : FAMILY_V4);

    // selected set depth and entry compare
    always_comb
    begin
        case (sel_reg)
            SET_CG:
            begin
                sel_depth = CNT_W'(CGROUP_ENTRIES);
                ent_valid = cg_rd_reg[64];
                ent_match = cg_rd_reg[63:0] == item_reg.group_id;
                hit_cause = CAUSE_CGROUP;
            end
            SET_V4:
            begin
                sel_depth = CNT_W'(IPV4_ENTRIES);
                ent_valid = v4_rd_reg[32];
                ent_match = v4_rd_reg[31:0] == v4_key;
                hit_cause = mapped_reg ? CAUSE_MAPPED : CAUSE_IPV4;
            end
            SET_V6:
            begin
                sel_depth = CNT_W'(IPV6_ENTRIES);
                ent_valid = v6_rd_reg[128];
                ent_match = v6_rd_reg[127:0] == {item_reg.dest_ipv6_high, item_reg.dest_ipv6_low};
                hit_cause = CAUSE_IPV6;
            end
            default:
            begin
                sel_depth = CNT_W'(PORT_ENTRIES);
                ent_valid = pt_rd_reg[16];
                ent_match = pt_rd_reg[15:0] == item_reg.dest_port;
                hit_cause = CAUSE_PORT;
            end
        endcase
    end

    assign hit            = pend_reg && ent_valid && ent_match;
    assign last           = pend_reg && (pidx_reg == sel_depth - CNT_W'(1));
    assign probe_end      = (state_reg == ST_SCAN) && (hit || last);
    assign free_now_found = free_found_reg || (pend_reg && !ent_valid);
    assign free_now_idx   = free_found_reg ? free_idx_reg : pidx_reg;
    assign issue          = (state_reg == ST_SCAN) && !hit && !last && (cnt_reg < sel_depth);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        sel_next          = sel_reg;
        mapped_next       = mapped_reg;
        cnt_next          = cnt_reg;
        pend_next         = 1'b0;
        pidx_next         = pidx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        checked_next      = checked_reg;
        blocked_next      = blocked_reg;
        allowed_next      = allowed_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        w_en              = 1'b0;
        w_all             = 1'b0;
        w_idx             = cnt_reg;
        w_val             = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                w_en  = 1'b1;
                w_all = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CLEAR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cnt_next        = '0;
                free_found_next = 1'b0;
                mapped_next     = 1'b0;
                state_next      = ST_SCAN;
                case (item_reg.mode)
                    MODE_CHECK:
                    begin
                        sel_next = SET_CG;
                        if (!fam_ok)
                        begin
                            state_next        = ST_IDLE;
                            result_valid_next = 1'b1;
                            result_next = '{1'b1, CAUSE_FAMILY, 1'b0,
                                            checked_reg, blocked_reg, allowed_reg};
                        end
                    end
                    MODE_WR_CGROUP: sel_next = SET_CG;
                    MODE_WR_IPV4:   sel_next = SET_V4;
                    MODE_WR_IPV6:   sel_next = SET_V6;
                    MODE_WR_PORT:   sel_next = SET_PT;
                    default:
                    begin
                        state_next        = ST_IDLE;
                        result_valid_next = 1'b1;
                        result_next = '{1'b0, CAUSE_ALLOWED, 1'b0,
                                        checked_reg, blocked_reg, allowed_reg};
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                if (pend_reg && !ent_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pidx_reg;
                end
                if (probe_end)
                begin
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    if (item_reg.mode == MODE_CHECK)
                    begin
                        if (hit || (sel_reg == SET_PT))
                        begin
                            checked_next = checked_reg + 64'd1;
                            if (hit)
                            begin
                                blocked_next = blocked_reg + 64'd1;
                            end
                            else
                            begin
                                allowed_next = allowed_reg + 64'd1;
                            end
                            state_next        = ST_IDLE;
                            result_valid_next = 1'b1;
                            result_next = '{!hit, hit ? hit_cause : CAUSE_ALLOWED, 1'b0,
                                            checked_next, blocked_next, allowed_next};
                        end
                        else
                        begin
                            case (sel_reg)
                                SET_CG: sel_next = item_reg.hook_is_ipv6 ? SET_V6 : SET_V4;
                                SET_V6:
                                begin
                                    sel_next    = is_mapped ? SET_V4 : SET_PT;
                                    mapped_next = is_mapped;
                                end
                                default: sel_next = SET_PT;
                            endcase
                        end
                    end
                    else
                    begin
                        // write modes: remove at hit, insert at lowest free slot
                        state_next        = ST_IDLE;
                        result_valid_next = 1'b1;
                        result_next = '{1'b0, CAUSE_ALLOWED, 1'b1,
                                        checked_reg, blocked_reg, allowed_reg};
                        if (!item_reg.entry_blocked)
                        begin
                            w_en  = hit;
                            w_idx = pidx_reg;
                            w_val = 1'b0;
                        end
                        else if (!hit)
                        begin
                            w_en  = free_now_found;
                            w_idx = free_now_idx;
                            w_val = 1'b1;
                            result_next.write_done = free_now_found;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (w_en && (w_all ? (cnt_reg < CNT_W'(CGROUP_ENTRIES)) : (sel_reg == SET_CG)))
        begin
            cg_mem[w_idx[CG_AW-1:0]] <= {w_val, item_reg.group_id};
        end
        if (w_en && (w_all ? (cnt_reg < CNT_W'(IPV4_ENTRIES)) : (sel_reg == SET_V4)))
        begin
            v4_mem[w_idx[V4_AW-1:0]] <= {w_val, item_reg.dest_ipv4};
        end
        if (w_en && (w_all ? (cnt_reg < CNT_W'(IPV6_ENTRIES)) : (sel_reg == SET_V6)))
        begin
            v6_mem[w_idx[V6_AW-1:0]] <= {w_val, item_reg.dest_ipv6_high, item_reg.dest_ipv6_low};
        end
        if (w_en && (w_all ? (cnt_reg < CNT_W'(PORT_ENTRIES)) : (sel_reg == SET_PT)))
        begin
            pt_mem[w_idx[PT_AW-1:0]] <= {w_val, item_reg.dest_port};
        end
        if (issue && (sel_reg == SET_CG))
        begin
            cg_rd_reg <= cg_mem[cnt_reg[CG_AW-1:0]];
        end
        if (issue && (sel_reg == SET_V4))
        begin
            v4_rd_reg <= v4_mem[cnt_reg[V4_AW-1:0]];
        end
        if (issue && (sel_reg == SET_V6))
        begin
            v6_rd_reg <= v6_mem[cnt_reg[V6_AW-1:0]];
        end
        if (issue && (sel_reg == SET_PT))
        begin
            pt_rd_reg <= pt_mem[cnt_reg[PT_AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        mapped_reg    <= mapped_next;
        pidx_reg      <= pidx_next;
        free_idx_reg  <= free_idx_next;
        result_reg    <= result_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            sel_reg          <= SET_CG;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            free_found_reg   <= 1'b0;
            checked_reg      <= '0;
            blocked_reg      <= '0;
            allowed_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sel_reg          <= sel_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            free_found_reg   <= free_found_next;
            checked_reg      <= checked_next;
            blocked_reg      <= blocked_next;
            allowed_reg      <= allowed_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `CBF_ASSERT_NXT(a_accept_busy, start && !busy, busy && !result_valid)
    `CBF_ASSERT_IMP(a_result_idle, result_valid, !busy)
    `CBF_ASSERT_IMP(a_allow_cause, result_valid && result.allowed,
                    (result.cause == CAUSE_ALLOWED) || (result.cause == CAUSE_FAMILY))
    `CBF_ASSERT_IMP(a_write_verdict, result_valid && result.write_done,
                    !result.allowed && (result.cause == CAUSE_ALLOWED))

endmodule
